>>> rtl/kct_pkg.sv
package kct_pkg;

   localparam int ITEM_KEY_W = 32;
   localparam int AMOUNT_W   = 16;
   localparam int COUNT_W    = 32;
   localparam int OCC_W      = 8;
   localparam int STATUS_W   = 3;
   localparam int REQ_DATA_W = ITEM_KEY_W + AMOUNT_W;
   localparam int RSP_DATA_W = COUNT_W + OCC_W;

   typedef logic [STATUS_W-1:0] status_type;

   localparam logic KIND_ADD    = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   localparam status_type STATUS_MERGED       = 3'd0;
   localparam status_type STATUS_INSERTED     = 3'd1;
   localparam status_type STATUS_DECREMENTED  = 3'd2;
   localparam status_type STATUS_DELETED      = 3'd3;
   localparam status_type STATUS_FULL         = 3'd4;
   localparam status_type STATUS_EMPTY        = 3'd5;
   localparam status_type STATUS_NOT_FOUND    = 3'd6;
   localparam status_type STATUS_INSUFFICIENT = 3'd7;

endpackage

>>> rtl/keyed_count_table.sv
// Full, empty and an insert into an empty table go from idle straight to the done state;
// other requests scan the entries, and the scan stops at the hit and a delete then shifts
// only the entries past it.
// One request at a time: a new request is taken only in idle, and a result still held in
// the output register stalls the next one.
// Reset (synchronous, active high) empties the table and drops a pending result;
// entry memory contents are not cleared, only entries below the occupancy are read.
module keyed_count_table #(
   parameter int CAPACITY = 128,
   parameter int KEY_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [kct_pkg::REQ_DATA_W-1:0]   req_tdata,   // [31:0] item_key, [47:32] amount
   input  logic                             req_tuser,   // [0] kind
   // Result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [kct_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [31:0] entry_count, [39:32] occupancy
   output kct_pkg::status_type              rsp_tuser    // [2:0] status
);
   import kct_pkg::*;

   // Only the low KEY_BITS bits of the key take part; the field itself is 32 bits.
   localparam int KEY_W  = (KEY_BITS < ITEM_KEY_W) ? KEY_BITS : ITEM_KEY_W;
   localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int WORD_W = KEY_W + COUNT_W;

   // Sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SEARCH = 3'd1;
   localparam logic [2:0] ST_MODIFY = 3'd2;
   localparam logic [2:0] ST_SHIFT  = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   // Entry memory: {key, count} per entry, registered read port
   logic [WORD_W-1:0] mem [CAPACITY];
   logic [WORD_W-1:0] mem_q;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;

   logic [2:0]          state_ff, state_in;
   logic                kind_ff, kind_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [AMOUNT_W-1:0] amount_ff, amount_in;
   logic [AW-1:0]       scan_ff, scan_in;
   logic [CW-1:0]       used_ff, used_in;
   logic [COUNT_W-1:0]  hit_count_ff, hit_count_in;
   status_type          status_ff, status_in;
   logic [COUNT_W-1:0]  result_ff, result_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   status_type          rsp_status_ff, rsp_status_in;

   logic [KEY_W-1:0]    mem_key;
   logic [COUNT_W-1:0]  mem_count;
   logic                last_entry;
   logic [AW-1:0]       scan_next;
   logic [COUNT_W:0]    sum_wide;
   logic [COUNT_W-1:0]  sum_sat;
   logic [COUNT_W-1:0]  amount_ext;
   logic [COUNT_W-1:0]  diff;

   assign mem_key    = mem_q[WORD_W-1:COUNT_W];
   assign mem_count  = mem_q[COUNT_W-1:0];
   assign scan_next  = scan_ff + AW'(1);
   assign last_entry = (CW'(scan_ff) + CW'(1)) == used_ff;
   assign amount_ext = COUNT_W'(amount_ff);
   // Saturate the merge at the count's maximum
   assign sum_wide   = {1'b0, hit_count_ff} + {1'b0, amount_ext};
   assign sum_sat    = sum_wide[COUNT_W] ? {COUNT_W{1'b1}} : sum_wide[COUNT_W-1:0];
   assign diff       = hit_count_ff - amount_ext;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      amount_in     = amount_ff;
      scan_in       = scan_ff;
      used_in       = used_ff;
      hit_count_in  = hit_count_ff;
      status_in     = status_ff;
      result_in     = result_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rd_en         = 1'b0;
      rd_addr       = scan_next;
      wr_en         = 1'b0;
      wr_addr       = scan_ff;
      wr_data       = {key_ff, amount_ext};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in   = req_tuser;
               key_in    = req_tdata[KEY_W-1:0];
               amount_in = req_tdata[ITEM_KEY_W +: AMOUNT_W];
               scan_in   = '0;
               result_in = '0;
               if (req_tuser == KIND_ADD) begin
                  if (used_ff == CW'(CAPACITY)) begin
                     status_in = STATUS_FULL;
                     state_in  = ST_DONE;
                  end else if (used_ff == '0) begin
                     // Empty table: append at entry zero without a scan
                     wr_en     = 1'b1;
                     wr_addr   = '0;
                     wr_data   = {req_tdata[KEY_W-1:0],
                                  COUNT_W'(req_tdata[ITEM_KEY_W +: AMOUNT_W])};
                     used_in   = used_ff + CW'(1);
                     result_in = COUNT_W'(req_tdata[ITEM_KEY_W +: AMOUNT_W]);
                     status_in = STATUS_INSERTED;
                     state_in  = ST_DONE;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     state_in = ST_SEARCH;
                  end
               end else begin
                  if (used_ff == '0) begin
                     status_in = STATUS_EMPTY;
                     state_in  = ST_DONE;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     state_in = ST_SEARCH;
                  end
               end
            end
         end

         // mem_q holds the entry at scan_ff; prefetch the next one while the scan goes on
         ST_SEARCH: begin
            if (mem_key == key_ff) begin
               hit_count_in = mem_count;
               state_in     = ST_MODIFY;
            end else if (last_entry) begin
               if (kind_ff == KIND_ADD) begin
                  wr_en     = 1'b1;
                  wr_addr   = used_ff[AW-1:0];
                  used_in   = used_ff + CW'(1);
                  result_in = amount_ext;
                  status_in = STATUS_INSERTED;
               end else begin
                  status_in = STATUS_NOT_FOUND;
               end
               state_in = ST_DONE;
            end else begin
               rd_en   = 1'b1;
               scan_in = scan_next;
            end
         end

         ST_MODIFY: begin
            if (kind_ff == KIND_ADD) begin
               wr_en     = 1'b1;
               wr_data   = {key_ff, sum_sat};
               result_in = sum_sat;
               status_in = STATUS_MERGED;
               state_in  = ST_DONE;
            end else if (amount_ext > hit_count_ff) begin
               status_in = STATUS_INSUFFICIENT;
               state_in  = ST_DONE;
            end else if (diff != '0) begin
               wr_en     = 1'b1;
               wr_data   = {key_ff, diff};
               result_in = diff;
               status_in = STATUS_DECREMENTED;
               state_in  = ST_DONE;
            end else if (last_entry) begin
               // Deleting the tail entry: nothing to shift
               used_in   = used_ff - CW'(1);
               status_in = STATUS_DELETED;
               state_in  = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               scan_in  = scan_next;
               state_in = ST_SHIFT;
            end
         end

         // Move entry scan_ff down one place, reading ahead one entry
         ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = scan_ff - AW'(1);
            wr_data = mem_q;
            if (last_entry) begin
               used_in   = used_ff - CW'(1);
               status_in = STATUS_DELETED;
               state_in  = ST_DONE;
            end else begin
               rd_en   = 1'b1;
               scan_in = scan_next;
            end
         end

         // Hand the result to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = {OCC_W'(used_ff), result_ff};
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      amount_ff     <= amount_in;
      scan_ff       <= scan_in;
      hit_count_ff  <= hit_count_in;
      status_ff     <= status_in;
      result_ff     <= result_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule
